FILE: src/crex_pkg.sv
// shared types, constants and helper functions of the cell rectangle expander
package crex_pkg;

  localparam int COORD_W      = 13;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int SLOT_W       = 8;
  localparam int WORD_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int WORD_BYTES   = WORD_W / BYTE_W;
  localparam int FMT_W        = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int PAL_ENTRIES_DEF = 256;
  localparam int MAX_DIM_DEF     = 4096;

  // axis numbering for the per-axis arrays
  localparam int AX_COL = 0;
  localparam int AX_ROW = 1;

  // input word function codes
  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_CELL    = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd6;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SEED = 4'b0100,
    ST_RUN  = 4'b1000
  } state_t;

  typedef logic [COORD_W-1:0] coord_t;

  // round-half-even of q + r/n, given r < n
  function automatic coord_t edge_round(coord_t q, coord_t r, coord_t n);
    logic [COORD_W:0] twice_r;
    logic [COORD_W:0] n_ext;
    logic             up;
    twice_r = {r, 1'b0};
    n_ext   = {1'b0, n};
    up      = (twice_r > n_ext) || ((twice_r == n_ext) && q[0]);
    return q + coord_t'(up);
  endfunction

  // pack 1 to 4 bytes of a raw value, first memory byte in the low byte
  function automatic logic [WORD_W-1:0] encode_pixel(logic [WORD_W-1:0] v,
                                                      logic [FMT_W-1:0] fmt);
    logic [WORD_W-1:0] word;
    logic [2:0]        nbytes;
    logic [1:0]        src;
    word   = '0;
    nbytes = {1'b0, fmt[1:0]} + 3'd1;
    for (int k = 0; k < WORD_BYTES; k++) begin
      if (3'(k) < nbytes) begin
        src = fmt[2] ? 2'(nbytes - 3'd1 - 3'(k)) : 2'(k);
        word[k*BYTE_W +: BYTE_W] = v[src*BYTE_W +: BYTE_W];
      end
    end
    return word;
  endfunction

endpackage

FILE: src/cell_array_rect_expander_core.sv
// cell array to pixel rectangle expander: palette, edge accumulators, pixel packing
//
//   channel | dir | handshake            | payload
//   in      | in  | in_valid / in_ready  | func, palette slot/value, cell color
//   out     | out | out_valid/out_ready  | rect x/y/w/h, pixel word, last cell
//   cfg     | in  | cfg_wr_en            | cfg_index, cfg_wdata (no wait, no read-back)
//
// one word per cycle in and out while in ST_RUN and not held by out_ready; a cell result
// passes the palette read register, then the result register; palette writes give no result
// after reset and after every register write, two 13-step restoring dividers
// split size/cells per axis: in_ready stays low through the load, divide and seed states
// edges then advance by one add and compare per cell, no per-cell division
// out_ready low holds the result; the stage behind it keeps one more word
module cell_array_rect_expander_core
  import crex_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF,
  parameter int MAX_DIMENSION   = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [SLOT_W-1:0]    in_palette_slot,
  input  logic [WORD_W-1:0]    in_palette_value,
  input  logic [SLOT_W-1:0]    in_cell_color,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   out_rect_x,
  output logic [COORD_W-1:0]   out_rect_y,
  output logic [COORD_W-1:0]   out_rect_w,
  output logic [COORD_W-1:0]   out_rect_h,
  output logic [WORD_W-1:0]    out_pixel_word,
  output logic                 out_last_cell
);

  localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam coord_t DIM_SAT = (MAX_DIMENSION > COORD_MAX) ?
                               coord_t'(COORD_MAX) : coord_t'(MAX_DIMENSION);
  localparam int DIV_STEPS = COORD_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // configuration
  coord_t           img_w_r, img_h_r, cells_x_r, cells_y_r;
  logic             mirror_x_r, mirror_y_r;
  logic [FMT_W-1:0] pix_fmt_r;
  logic             cfg_hit;

  coord_t size_eff  [2];
  coord_t cells_eff [2];

  // control and dividers
  state_t              state_r, state_nxt;
  logic [DIV_CW-1:0]   div_cnt_r;
  coord_t              div_quo_r [2];
  coord_t              div_rem_r [2];
  logic [COORD_W:0]    div_t     [2];
  logic                div_ge    [2];

  // scan state per axis; far edge kept as quotient and remainder
  coord_t cnt_r  [2];
  coord_t near_r [2];
  coord_t fq_r   [2];
  coord_t fr_r   [2];
  coord_t fq_adv [2];
  coord_t fr_adv [2];
  coord_t edge_v [2];
  logic   last_v [2];
  logic [COORD_W:0] fr_sum [2];
  logic             fr_wrap [2];

  // pipeline
  logic accept, cell_acc, pal_wr, slot_ok, color_ok;
  logic s2_adv, s1_ready;
  logic s1_v_r, s1_v_nxt, out_valid_r, out_valid_nxt;
  logic [15:0] slot_ext, color_ext;

  coord_t            s1_x_r, s1_y_r, s1_w_r, s1_h_r;
  logic              s1_last_r, s1_pal_ok_r;
  logic [WORD_W-1:0] pal_rd_r;
  coord_t            geo_x, geo_y;

  coord_t            out_x_r, out_y_r, out_w_r, out_h_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_last_r;

  logic [WORD_W-1:0] pal_mem [PALETTE_ENTRIES];

  always_comb begin
    size_eff[AX_COL]  = (img_w_r > DIM_SAT) ? DIM_SAT : img_w_r;
    size_eff[AX_ROW]  = (img_h_r > DIM_SAT) ? DIM_SAT : img_h_r;
    cells_eff[AX_COL] = (cells_x_r == '0) ? coord_t'(1) :
                        ((cells_x_r > DIM_SAT) ? DIM_SAT : cells_x_r);
    cells_eff[AX_ROW] = (cells_y_r == '0) ? coord_t'(1) :
                        ((cells_y_r > DIM_SAT) ? DIM_SAT : cells_y_r);
  end

  assign cfg_hit = cfg_wr_en && (cfg_index <= CFG_PIXEL_FORMAT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= coord_t'(1);
      img_h_r    <= coord_t'(1);
      cells_x_r  <= coord_t'(1);
      cells_y_r  <= coord_t'(1);
      mirror_x_r <= 1'b0;
      mirror_y_r <= 1'b0;
      pix_fmt_r  <= FMT_W'(3);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r    <= cfg_wdata;
        CFG_IMAGE_HEIGHT: img_h_r    <= cfg_wdata;
        CFG_CELLS_X:      cells_x_r  <= cfg_wdata;
        CFG_CELLS_Y:      cells_y_r  <= cfg_wdata;
        CFG_MIRROR_X:     mirror_x_r <= cfg_wdata[0];
        CFG_MIRROR_Y:     mirror_y_r <= cfg_wdata[0];
        CFG_PIXEL_FORMAT: pix_fmt_r  <= cfg_wdata[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // restoring division size / cells, one quotient bit per cycle per axis
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      div_t[a]  = {div_rem_r[a], div_quo_r[a][COORD_W-1]};
      div_ge[a] = div_t[a] >= {1'b0, cells_eff[a]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (div_cnt_r == DIV_CW'(DIV_STEPS - 1)) state_nxt = ST_SEED;
      ST_SEED: state_nxt = ST_RUN;
      ST_RUN:  state_nxt = ST_RUN;
      default: state_nxt = ST_LOAD;
    endcase
    if (cfg_hit) state_nxt = ST_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOAD) div_cnt_r <= '0;
      else if (state_r == ST_DIV) div_cnt_r <= div_cnt_r + DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      if (state_r == ST_LOAD) begin
        div_rem_r[a] <= '0;
        div_quo_r[a] <= size_eff[a];
      end else if (state_r == ST_DIV) begin
        div_rem_r[a] <= div_ge[a] ? coord_t'(div_t[a] - {1'b0, cells_eff[a]})
                                  : coord_t'(div_t[a]);
        div_quo_r[a] <= {div_quo_r[a][COORD_W-2:0], div_ge[a]};
      end
    end
  end

  // far edge accumulators advance by quotient and remainder of size/cells
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      fr_sum[a]  = {1'b0, fr_r[a]} + {1'b0, div_rem_r[a]};
      fr_wrap[a] = fr_sum[a] >= {1'b0, cells_eff[a]};
      fr_adv[a]  = fr_wrap[a] ? coord_t'(fr_sum[a] - {1'b0, cells_eff[a]})
                              : coord_t'(fr_sum[a]);
      fq_adv[a]  = fq_r[a] + div_quo_r[a] + coord_t'(fr_wrap[a]);
      edge_v[a]  = edge_round(fq_r[a], fr_r[a], cells_eff[a]);
      last_v[a]  = ({1'b0, cnt_r[a]} + 1'b1) >= {1'b0, cells_eff[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 2; a++) begin
        cnt_r[a]  <= '0;
        near_r[a] <= '0;
      end
    end else if ((state_r == ST_SEED) || (cell_acc && last_v[AX_COL] && last_v[AX_ROW])) begin
      for (int a = 0; a < 2; a++) begin
        cnt_r[a]  <= '0;
        near_r[a] <= '0;
        fq_r[a]   <= div_quo_r[a];
        fr_r[a]   <= div_rem_r[a];
      end
    end else if (cell_acc) begin
      if (!last_v[AX_COL]) begin
        cnt_r[AX_COL]  <= cnt_r[AX_COL] + coord_t'(1);
        near_r[AX_COL] <= edge_v[AX_COL];
        fq_r[AX_COL]   <= fq_adv[AX_COL];
        fr_r[AX_COL]   <= fr_adv[AX_COL];
      end else begin
        cnt_r[AX_COL]  <= '0;
        near_r[AX_COL] <= '0;
        fq_r[AX_COL]   <= div_quo_r[AX_COL];
        fr_r[AX_COL]   <= div_rem_r[AX_COL];
        cnt_r[AX_ROW]  <= cnt_r[AX_ROW] + coord_t'(1);
        near_r[AX_ROW] <= edge_v[AX_ROW];
        fq_r[AX_ROW]   <= fq_adv[AX_ROW];
        fr_r[AX_ROW]   <= fr_adv[AX_ROW];
      end
    end
  end

  // handshake and pipeline control
  assign s2_adv   = !out_valid_r || out_ready;
  assign s1_ready = !s1_v_r || s2_adv;
  assign in_ready = s1_ready && (state_r == ST_RUN);
  assign accept   = in_valid && in_ready;
  assign cell_acc = accept && (in_func == FUNC_CELL);

  assign slot_ext  = 16'(in_palette_slot);
  assign color_ext = 16'(in_cell_color);
  assign slot_ok   = 32'(in_palette_slot) < 32'(PALETTE_ENTRIES);
  assign color_ok  = 32'(in_cell_color) < 32'(PALETTE_ENTRIES);
  assign pal_wr    = accept && (in_func == FUNC_PALETTE) && slot_ok;

  assign s1_v_nxt      = s1_ready ? cell_acc : s1_v_r;
  assign out_valid_nxt = s2_adv ? s1_v_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_wr) pal_mem[slot_ext[PAL_AW-1:0]] <= in_palette_value;
  end

  assign geo_x = mirror_x_r ? size_eff[AX_COL] - edge_v[AX_COL] : near_r[AX_COL];
  assign geo_y = mirror_y_r ? size_eff[AX_ROW] - edge_v[AX_ROW] : near_r[AX_ROW];

  always_ff @(posedge clk) begin
    if (cell_acc) begin
      pal_rd_r    <= pal_mem[color_ext[PAL_AW-1:0]];
      s1_pal_ok_r <= color_ok;
      s1_x_r      <= geo_x;
      s1_y_r      <= geo_y;
      s1_w_r      <= edge_v[AX_COL] - near_r[AX_COL];
      s1_h_r      <= edge_v[AX_ROW] - near_r[AX_ROW];
      s1_last_r   <= last_v[AX_COL] && last_v[AX_ROW];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_v_r) begin
      out_x_r    <= s1_x_r;
      out_y_r    <= s1_y_r;
      out_w_r    <= s1_w_r;
      out_h_r    <= s1_h_r;
      out_last_r <= s1_last_r;
      out_word_r <= encode_pixel(s1_pal_ok_r ? pal_rd_r : '0, pix_fmt_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rect_x     = out_x_r;
  assign out_rect_y     = out_y_r;
  assign out_rect_w     = out_w_r;
  assign out_rect_h     = out_h_r;
  assign out_pixel_word = out_word_r;
  assign out_last_cell  = out_last_r;

  // divider remainders stay below the cell counts once running
  a_col_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (div_rem_r[AX_COL] < cells_eff[AX_COL]))
    else $error("column step remainder not below cell count");

  a_row_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (div_rem_r[AX_ROW] < cells_eff[AX_ROW]))
    else $error("row step remainder not below cell count");

  // scan position never passes the last cell
  a_col_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((cnt_r[AX_COL] < cells_eff[AX_COL]) &&
                             (cnt_r[AX_ROW] < cells_eff[AX_ROW])))
    else $error("scan count beyond cell array");

  // edges are monotonic within a row and a column
  a_col_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (near_r[AX_COL] <= edge_v[AX_COL]))
    else $error("column near edge past far edge");

  a_row_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (near_r[AX_ROW] <= edge_v[AX_ROW]))
    else $error("row near edge past far edge");

endmodule
